/* rtl/core/mhbh_pkg.sv */
// Package: shared types and constants of the block hasher.
`timescale 1ns / 1ps
`default_nettype none
package mhbh_pkg;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned ADDR_W = 16;
  localparam int unsigned CFG_W = 13;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned MEM_WORDS = 65536;
  localparam int unsigned MEM_AW = 16;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_LANE  = 2'd2;
  localparam logic [1:0] REQ_HASH  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WORDS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUB_WORDS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MULT_ROUNDS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PASS_COUNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LANE_COUNT  = 3'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] word_addr;
    logic [2:0]  lane_sel;
    logic [31:0] wdata;
    logic [15:0] source_base;
    logic [15:0] previous_base;
    logic [15:0] dest_base;
  } req_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic [2:0]  out_lane;
    logic [31:0] chain_word;
    logic        last;
  } res_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD_ISSUE, ST_RD_WAIT, ST_RD_OUT,
    ST_SEL_ISSUE, ST_SEL_WAIT, ST_GROUP,
    ST_MUL_BC, ST_MUL_AD, ST_MUL_CD,
    ST_PW_ISSUE, ST_PW_WAIT, ST_LANE,
    ST_OUT
  } state_t;

  // floor power of two of a 13-bit value (value >= 1)
  function automatic logic [12:0] floor_pow2(input logic [12:0] v);
    logic [12:0] p;
    p = 13'd1;
    for (int i = 12; i >= 0; i--) begin
      if (v[i] && p == 13'd1) p = 13'(1) << i;
    end
    return p;
  endfunction

  function automatic logic [31:0] rotl8(input logic [31:0] x);
    return {x[23:0], x[31:24]};
  endfunction
endpackage
`default_nettype wire

/* rtl/core/mhbh_req_if.sv */
// Interfaces: request and result channels.
`timescale 1ns / 1ps
`default_nettype none
interface mhbh_req_if;
  import mhbh_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface mhbh_res_if;
  import mhbh_pkg::*;
  logic valid;
  logic ready;
  res_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/core/memory_hard_block_hasher_top.sv */
// Top level: word memory, lane state and hash sequencer.
// Write and lane load are taken in idle; a read gives one beat from the registered word.
// Hash, per pass: a selector read per sub-block, the multiply rounds of chain work per lane
// group, two reads per lane word and, in the last pass only, one write per lane word; then
// one beat per lane. One request at a time: ready stays low until its last beat is taken.
// Reset clears lane state and sets registers to defaults; memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module memory_hard_block_hasher_top #(
  parameter int unsigned MAX_LANES = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  mhbh_req_if.sink                             req,
  mhbh_res_if.source                           res,
  input  wire logic                            cfg_we,
  input  wire logic [mhbh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mhbh_pkg::CFG_W-1:0]      cfg_wdata
);
  import mhbh_pkg::*;
  localparam int unsigned LCAP = (MAX_LANES < 8) ? MAX_LANES : 8;

  logic [12:0] block_words, sub_block_words, pass_count;
  logic [3:0]  mult_rounds, lane_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_words <= 13'd256; sub_block_words <= 13'd64;
      mult_rounds <= 4'd2; pass_count <= 13'd1; lane_count <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLOCK_WORDS: block_words <= cfg_wdata;
        CFG_SUB_WORDS:   sub_block_words <= cfg_wdata;
        CFG_MULT_ROUNDS: mult_rounds <= cfg_wdata[3:0];
        CFG_PASS_COUNT:  pass_count <= cfg_wdata;
        CFG_LANE_COUNT:  lane_count <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // effective settings
  logic [12:0] bw_c, sw_c, bw_e, sw_e, passes_e, lanes_p;
  logic [3:0]  rounds_e, lanes_c, lanes_e;
  always_comb begin
    bw_c = (block_words < 13'd8) ? 13'd8 : (block_words > 13'd4096 ? 13'd4096 : block_words);
    bw_e = floor_pow2(bw_c);
    sw_c = (sub_block_words < 13'd8) ? 13'd8 :
           (sub_block_words > bw_e ? bw_e : sub_block_words);
    sw_e = floor_pow2(sw_c);
    rounds_e = (mult_rounds > 4'd8) ? 4'd8 : mult_rounds;
    passes_e = (pass_count == 13'd0) ? 13'd1 :
               (pass_count > 13'd4096 ? 13'd4096 : pass_count);
    lanes_c = (lane_count == 4'd0) ? 4'd1 :
              (lane_count > 4'(LCAP) ? 4'(LCAP) : lane_count);
    lanes_p = floor_pow2({9'd0, lanes_c});
    lanes_e = lanes_p[3:0];
  end

  // word memory
  logic [31:0]       mem [MEM_WORDS];
  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]       mem_wdata, mem_rdata;
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata <= mem[mem_raddr];
  end

  // multiplier
  logic [31:0] mul_a, mul_b, mul_hi;
  mhbh_mulhi u_mul (.clk(clk), .op_a(mul_a), .op_b(mul_b), .hi(mul_hi));

  state_t state, state_next;
  req_t   cur;
  logic [31:0] lane_st [8];
  logic [31:0] ca, cb, cc, cd, pw, rd_word;
  logic [12:0] r_cnt;     // pass
  logic [12:0] fo;        // offset in source block (up to 4095)
  logic [12:0] po;        // offset in previous block
  logic [12:0] wcnt;      // words done in sub-block
  logic [3:0]  m_cnt;
  logic [2:0]  k;
  logic [2:0]  o_cnt;

  logic store, lane_last, sub_last, pass_done;
  assign store = (r_cnt + 13'd1 == passes_e);
  assign lane_last = ({1'b0, k} + 4'd1 == lanes_e);
  assign sub_last = lane_last && (wcnt + {9'd0, lanes_e} == sw_e);
  assign pass_done = (fo + 13'd1 == bw_e);

  // addresses wrap at the memory size
  function automatic logic [MEM_AW-1:0] wa(input logic [15:0] b, input logic [12:0] o);
    logic [16:0] s;
    s = {1'b0, b} + {4'd0, o};
    return s[MEM_AW-1:0];
  endfunction

  always_comb begin
    state_next = state;
    mem_raddr = wa(cur.source_base, fo);
    mul_a = cb; mul_b = cc;
    req.ready = 1'b0;
    res.valid = 1'b0;
    res.payload = '0;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          case (req.payload.req_type)
            REQ_READ: state_next = ST_RD_ISSUE;
            REQ_HASH: state_next = ST_SEL_ISSUE;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_RD_ISSUE: begin mem_raddr = wa(cur.word_addr, 13'd0); state_next = ST_RD_WAIT; end
      ST_RD_WAIT: state_next = ST_RD_OUT;
      ST_RD_OUT: begin
        res.valid = 1'b1;
        res.payload = '{rdata: rd_word, out_lane: 3'd0, chain_word: 32'd0, last: 1'b1};
        if (res.ready) state_next = ST_IDLE;
      end
      ST_SEL_ISSUE: state_next = ST_SEL_WAIT;
      ST_SEL_WAIT: state_next = ST_GROUP;
      ST_GROUP: state_next = (rounds_e != 4'd0) ? ST_MUL_BC : ST_PW_ISSUE;
      ST_MUL_BC: begin mul_a = cb; mul_b = cc; state_next = ST_MUL_AD; end
      ST_MUL_AD: begin mul_a = ca ^ mul_hi; mul_b = cd; state_next = ST_MUL_CD; end
      ST_MUL_CD: state_next = (m_cnt + 4'd1 < rounds_e) ? ST_MUL_BC : ST_PW_ISSUE;
      ST_PW_ISSUE: begin mem_raddr = wa(cur.previous_base, po); state_next = ST_PW_WAIT; end
      // source word is addressed here and lands for the lane update
      ST_PW_WAIT: state_next = ST_LANE;
      ST_LANE: begin
        if (!lane_last) state_next = ST_PW_ISSUE;
        else if (!sub_last) state_next = ST_GROUP;
        else if (!pass_done) state_next = ST_SEL_ISSUE;
        else if (store) state_next = ST_OUT;
        else state_next = ST_SEL_ISSUE;
      end
      ST_OUT: begin
        res.valid = 1'b1;
        res.payload = '{rdata: lane_st[o_cnt], out_lane: o_cnt, chain_word: ca,
                        last: ({1'b0, o_cnt} + 4'd1 == lanes_e)};
        if (res.ready && {1'b0, o_cnt} + 4'd1 == lanes_e) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  logic [31:0] new_lane;
  assign new_lane = rotl8((lane_st[k] + pw) ^ mem_rdata);

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = wa(cur.dest_base, fo);
    mem_wdata = new_lane;
    if (state == ST_IDLE && req.valid && req.payload.req_type == REQ_WRITE) begin
      mem_we = 1'b1;
      mem_waddr = wa(req.payload.word_addr, 13'd0);
      mem_wdata = req.payload.wdata;
    end else if (state == ST_LANE && store) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      for (int i = 0; i < 8; i++) lane_st[i] <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: if (req.valid) begin
          cur <= req.payload;
          if (req.payload.req_type == REQ_LANE) lane_st[req.payload.lane_sel] <= req.payload.wdata;
          ca <= lane_st[0]; cb <= lane_st[1]; cc <= lane_st[2]; cd <= lane_st[3];
          r_cnt <= '0; fo <= '0; wcnt <= '0; m_cnt <= '0; k <= '0; o_cnt <= '0;
        end
        ST_RD_WAIT: rd_word <= mem_rdata;
        ST_SEL_WAIT: begin
          // selected sub-block offset: (sel mod nsub) * sw, both powers of two
          po <= (mem_rdata[12:0] * sw_e) & (bw_e - 13'd1);
          wcnt <= '0;
        end
        ST_GROUP: begin k <= '0; m_cnt <= '0; end
        ST_MUL_AD: begin
          ca <= ca ^ mul_hi; cb <= cb + cc;
        end
        // second half of a round: c and d use the updated a
        ST_MUL_CD: begin
          cc <= cc ^ mul_hi; cd <= cd + ca; m_cnt <= m_cnt + 4'd1;
        end
        ST_PW_WAIT: pw <= mem_rdata;
        ST_LANE: begin
          lane_st[k] <= new_lane;
          po <= po + 13'd1;
          k <= k + 3'd1;
          if (lane_last) wcnt <= wcnt + {9'd0, lanes_e};
          if (pass_done) begin
            fo <= '0; r_cnt <= r_cnt + 13'd1;
          end else fo <= fo + 13'd1;
        end
        ST_OUT: if (res.ready) o_cnt <= o_cnt + 3'd1;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/core/mhbh_mulhi.sv */
// Shared 32x32 multiplier returning the registered high word.
`timescale 1ns / 1ps
`default_nettype none
module mhbh_mulhi (
  input  wire logic        clk,
  input  wire logic [31:0] op_a,
  input  wire logic [31:0] op_b,
  output logic [31:0]      hi
);
  import mhbh_pkg::*;
  logic [63:0] prod;
  assign prod = {32'd0, op_a} * {32'd0, op_b};
  always_ff @(posedge clk) begin
    hi <= prod[63:32];
  end
endmodule
`default_nettype wire
